>>> design/utt_pkg.sv
// Package for the UTF-8 to UTF-16 transcoder.
// Holds the format codes, decoder constants and the queue entry types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utt_pkg;

    localparam int FIFO_DEPTH = 2;

    localparam logic [1:0] FMT_PASS = 2'd0;
    localparam logic [1:0] FMT_LE   = 2'd1;
    localparam logic [1:0] FMT_BE   = 2'd2;

    localparam logic [7:0]  LEAD2_MASK = 8'hE0;
    localparam logic [7:0]  LEAD2_CODE = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK = 8'hF0;
    localparam logic [7:0]  LEAD3_CODE = 8'hE0;
    localparam logic [7:0]  LEAD2_BITS = 8'h1F;
    localparam logic [7:0]  LEAD3_BITS = 8'h0F;
    localparam logic [7:0]  CONT_BITS  = 8'h3F;
    localparam logic [15:0] REPL_UNIT  = 16'h003F;

    typedef struct packed {
        logic [15:0] unit;
        logic        single;
        logic        little;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

endpackage

`default_nettype wire

>>> design/utt_ifs.sv
// Channel interfaces for the transcoder: input bytes, output bytes and the
// configuration write channel. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface utt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_end;
    modport source (output valid, output in_byte, output string_end, input ready);
    modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

interface utt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

interface utt_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/utt_front.sv
// Front part: accepts input items, decodes UTF-8 and pushes code units.
// Depends on utt_pkg and utt_in_if.
`timescale 1ns / 1ps
`default_nettype none

module utt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [1:0]    i_format,
    input  wire logic          i_full,
    utt_in_if.sink             i_in,
    output utt_pkg::t_push     o_push
);
    import utt_pkg::*;

    logic [1:0]  r_pend,    n_pend;
    logic [15:0] r_partial, n_partial;
    logic        r_repl,    n_repl;
    logic [15:0] cont_val;
    logic [1:0]  pend_dec;
    logic        accept;
    logic [7:0]  b;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.in_byte;
    assign cont_val   = {r_partial[9:0], b[5:0] & CONT_BITS[5:0]};
    assign pend_dec   = r_pend - 2'd1;

    always_comb begin
        n_pend              = r_pend;
        n_partial           = r_partial;
        n_repl              = r_repl;
        o_push.valid        = 1'b0;
        o_push.entry.unit   = REPL_UNIT;
        o_push.entry.single = 1'b0;
        o_push.entry.little = (i_format == FMT_LE);
        if (accept) begin
            if (i_format == FMT_PASS) begin
                n_pend              = '0;
                n_partial           = '0;
                n_repl              = 1'b0;
                o_push.valid        = 1'b1;
                o_push.entry.unit   = {8'h00, b};
                o_push.entry.single = 1'b1;
            end else if (i_format != FMT_LE && i_format != FMT_BE) begin
                n_pend    = '0;
                n_partial = '0;
                n_repl    = 1'b0;
            end else if (r_pend == 2'd0) begin
                if (!b[7]) begin
                    o_push.valid      = 1'b1;
                    o_push.entry.unit = {8'h00, b};
                end else begin
                    if ((b & LEAD2_MASK) == LEAD2_CODE) begin
                        n_pend    = 2'd1;
                        n_partial = {8'h00, b & LEAD2_BITS};
                        n_repl    = 1'b0;
                    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
                        n_pend    = 2'd2;
                        n_partial = {8'h00, b & LEAD3_BITS};
                        n_repl    = 1'b0;
                    end else begin
                        n_pend    = 2'd3;
                        n_partial = '0;
                        n_repl    = 1'b1;
                    end
                    if (i_in.string_end) begin
                        n_pend       = '0;
                        n_partial    = '0;
                        n_repl       = 1'b0;
                        o_push.valid = 1'b1;
                    end
                end
            end else begin
                n_partial = cont_val;
                n_pend    = pend_dec;
                if (pend_dec == 2'd0) begin
                    o_push.valid      = 1'b1;
                    o_push.entry.unit = r_repl ? REPL_UNIT : cont_val;
                    n_partial         = '0;
                    n_repl            = 1'b0;
                end else if (i_in.string_end) begin
                    o_push.valid = 1'b1;
                    n_pend       = '0;
                    n_partial    = '0;
                    n_repl       = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_partial <= '0;
            r_repl    <= 1'b0;
        end else begin
            r_pend    <= n_pend;
            r_partial <= n_partial;
            r_repl    <= n_repl;
        end
    end

endmodule

`default_nettype wire

>>> design/utt_queue.sv
// Short queue of decoded code units between the front and back parts.
// Depends on utt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utt_queue #(
    parameter int DEPTH = utt_pkg::FIFO_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire utt_pkg::t_push i_push,
    input  wire logic          i_pop,
    output utt_pkg::t_head     o_head,
    output logic               o_full
);
    import utt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/utt_back.sv
// Back part: serialises each queued code unit into one or two output bytes.
// Depends on utt_pkg and utt_out_if.
`timescale 1ns / 1ps
`default_nettype none

module utt_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire utt_pkg::t_head i_head,
    output logic                o_pop,
    utt_out_if.source           o_out
);
    import utt_pkg::*;

    logic r_phase;
    logic take;
    logic low_first;

    assign take      = o_out.valid && o_out.ready;
    assign low_first = i_head.entry.little ^ r_phase;

    assign o_out.valid    = i_head.valid;
    assign o_out.out_byte = (i_head.entry.single || low_first) ? i_head.entry.unit[7:0]
                                                               : i_head.entry.unit[15:8];
    assign o_out.run_last = i_head.entry.single || r_phase;
    assign o_pop          = take && o_out.run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (take) begin
            r_phase <= !o_out.run_last;
        end
    end

endmodule

`default_nettype wire

>>> design/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder, top level. Accepted items are registered into
// the queue and their output bytes are offered from its head. Throughput:
// one input item per cycle while the queue is not full, one output byte per
// cycle while the output is ready. Synchronous active-low reset empties the
// queue, clears the decoder and selects pass-through.
// Depends on utt_pkg, utt_ifs, utt_front, utt_queue and utt_back.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_transcoder #(
    parameter int FIFO_DEPTH = utt_pkg::FIFO_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    utt_in_if.sink    i_in,
    utt_out_if.source o_out,
    utt_cfg_if.sink   i_cfg
);
    import utt_pkg::*;

    logic [1:0] r_format;
    t_push      push;
    t_head      head;
    logic       full;
    logic       pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_PASS;
        end else if (i_cfg.valid) begin
            r_format <= i_cfg.data;
        end
    end

    utt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_format (r_format),
        .i_full   (full),
        .i_in     (i_in),
        .o_push   (push)
    );

    utt_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    utt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

>>> design/utt_checker.sv
// Port-level checker for the transcoder and the bind that attaches it.
// Depends on the top level utf8_to_utf16_transcoder.
`timescale 1ns / 1ps
`default_nettype none

module utt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_run_last,
    input wire logic       i_cfg_ready
);

    // A full queue always has a result on offer.
    a_full_offers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no output on offer");

    // The first byte of a code unit is always followed by its second.
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_run_last) |=> i_out_valid)
        else $error("second byte of a code unit missing");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_run_last)))
        else $error("stalled output item changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output offered straight after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind utf8_to_utf16_transcoder utt_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_byte     (o_out.out_byte),
    .i_out_run_last (o_out.run_last),
    .i_cfg_ready    (i_cfg.ready)
);

`default_nettype wire

>>> bench/utt_checker.sv
// Scoreboard for the UTF-8 to UTF-16 transcoder. It watches the input, output and
// configuration channels, predicts every output byte and compares it in order.
// Depends on utt_pkg.
`timescale 1ns / 1ps

module utt_scoreboard (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_end,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_out_byte,
    input  wire logic       i_out_last,
    input  wire logic       i_cfg_valid,
    input  wire logic       i_cfg_ready,
    input  wire logic [1:0] i_cfg_data,
    output int              o_errors,
    output int              o_outstanding,
    output int              o_results
);
    import utt_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_byte;

    t_out_byte   expected_bytes[$];
    logic [1:0]  format_q;
    logic [1:0]  conts_left;
    logic [15:0] code_acc;
    logic        bad_seq;

    function automatic void drop_sequence();
        conts_left = 2'd0;
        code_acc   = 16'h0000;
        bad_seq    = 1'b0;
    endfunction

    function automatic void add_expected(input logic [7:0] value, input logic last_flag);
        t_out_byte slot;
        slot.data      = value;
        slot.last      = last_flag;
        expected_bytes = {expected_bytes, slot};
    endfunction

    function automatic void queue_code_unit(input logic [15:0] unit);
        if (format_q == FMT_LE) begin
            add_expected(unit[7:0], 1'b0);
            add_expected(unit[15:8], 1'b1);
        end else begin
            add_expected(unit[15:8], 1'b0);
            add_expected(unit[7:0], 1'b1);
        end
    endfunction

    function automatic void predict_from_byte(input logic [7:0] b, input logic str_end);
        logic [15:0] unit;
        if (format_q == FMT_PASS) begin
            drop_sequence();
            add_expected(b, 1'b1);
        end else if (format_q != FMT_LE && format_q != FMT_BE) begin
            drop_sequence();
        end else if (conts_left == 2'd0) begin
            if (!b[7]) begin
                queue_code_unit({8'h00, b});
            end else begin
                if ((b & LEAD2_MASK) == LEAD2_CODE) begin
                    conts_left = 2'd1;
                    code_acc   = {8'h00, b & LEAD2_BITS};
                    bad_seq    = 1'b0;
                end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
                    conts_left = 2'd2;
                    code_acc   = {8'h00, b & LEAD3_BITS};
                    bad_seq    = 1'b0;
                end else begin
                    conts_left = 2'd3;
                    code_acc   = 16'h0000;
                    bad_seq    = 1'b1;
                end
                if (str_end) begin
                    drop_sequence();
                    queue_code_unit(REPL_UNIT);
                end
            end
        end else begin
            code_acc   = {code_acc[9:0], b[5:0]};
            conts_left = conts_left - 2'd1;
            if (conts_left == 2'd0) begin
                unit = bad_seq ? REPL_UNIT : code_acc;
                drop_sequence();
                queue_code_unit(unit);
            end else if (str_end) begin
                drop_sequence();
                queue_code_unit(REPL_UNIT);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_byte head;
        if (!i_rst_n) begin
            format_q = FMT_PASS;
            drop_sequence();
            expected_bytes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results = o_results + 1;
                if (expected_bytes.size() == 0) begin
                    o_errors = o_errors + 1;
                    $display("%0t: unexpected output byte %h run_last %b",
                             $time, i_out_byte, i_out_last);
                end else begin
                    head = expected_bytes.pop_front();
                    if (i_out_byte !== head.data) begin
                        o_errors = o_errors + 1;
                        $display("%0t: out_byte expected %h, got %h",
                                 $time, head.data, i_out_byte);
                    end
                    if (i_out_last !== head.last) begin
                        o_errors = o_errors + 1;
                        $display("%0t: run_last expected %b, got %b",
                                 $time, head.last, i_out_last);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                format_q = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                predict_from_byte(i_in_byte, i_in_end);
            end
        end
        o_outstanding = expected_bytes.size();
    end

endmodule

>>> bench/tb.sv
// Top of the transcoder testbench: clock, reset, byte stimulus, format writes
// and output back-pressure, with the verdict taken from utt_scoreboard.
// Depends on utt_pkg, utt_ifs, utf8_to_utf16_transcoder and utt_scoreboard.
`timescale 1ns / 1ps

module tb;
    import utt_pkg::*;

    localparam logic [1:0] FMT_RESERVED = 2'd3;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum int {RX_OPEN, RX_COIN, RX_MASK, RX_BURSTY} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   errors;
    int   outstanding;
    int   results;
    int   cycles;
    int   bytes_sent;
    int   format_writes;
    int   burst_left;

    utt_in_if  in_ch();
    utt_out_if out_ch();
    utt_cfg_if cfg_ch();

    always #6 i_clk = ~i_clk;

    utf8_to_utf16_transcoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    utt_scoreboard u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_in_byte     (in_ch.in_byte),
        .i_in_end      (in_ch.string_end),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_out_byte    (out_ch.out_byte),
        .i_out_last    (out_ch.run_last),
        .i_cfg_valid   (cfg_ch.valid),
        .i_cfg_ready   (cfg_ch.ready),
        .i_cfg_data    (cfg_ch.data),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_results     (results)
    );

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: errors");
        $finish;
    end

    initial begin
        t_rx_mode    mode;
        int          span;
        int          hold;
        logic [7:0]  mask;
        out_ch.ready <= 1'b0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(40, 200);
            mask = 8'($urandom_range(1, 255));
            hold = 0;
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    RX_OPEN: begin
                        out_ch.ready <= 1'b1;
                    end
                    RX_COIN: begin
                        out_ch.ready <= 1'($urandom_range(0, 1));
                    end
                    RX_MASK: begin
                        out_ch.ready <= mask[0];
                        mask = {mask[0], mask[7:1]};
                    end
                    default: begin
                        if (hold > 0) begin
                            out_ch.ready <= 1'b0;
                            hold--;
                        end else begin
                            out_ch.ready <= 1'b1;
                            if ($urandom_range(0, 3) == 0) hold = $urandom_range(2, 8);
                        end
                    end
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic str_end);
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= b;
        in_ch.string_end <= str_end;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        @(negedge i_clk);
        bytes_sent++;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_format(input logic [1:0] fmt);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= fmt;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        format_writes++;
    endtask

    task automatic send_char(output int sent);
        logic [7:0] seq[$];
        int         kind;
        int         conts;
        int         cut;
        logic       str_done;
        kind  = $urandom_range(0, 15);
        conts = 0;
        if (kind < 5) begin
            seq = {seq, 8'($urandom_range(0, 127))};
        end else if (kind < 9) begin
            seq = {seq, 8'hC0 | 8'($urandom_range(0, 31))};
            conts = 1;
        end else if (kind < 13) begin
            seq = {seq, 8'hE0 | 8'($urandom_range(0, 15))};
            conts = 2;
        end else if (kind < 14) begin
            seq = {seq, ($urandom_range(0, 1) ? 8'hF0 | 8'($urandom_range(0, 15))
                                              : 8'h80 | 8'($urandom_range(0, 63)))};
            conts = 3;
        end else begin
            seq = {seq, 8'($urandom_range(0, 255))};
        end
        repeat (conts) begin
            seq = {seq, (($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'h80 | 8'($urandom_range(0, 63)))};
        end
        cut = seq.size();
        if (cut > 1 && $urandom_range(0, 11) == 0) cut = $urandom_range(1, cut - 1);
        str_done = (cut < seq.size()) || ($urandom_range(0, 7) == 0);
        for (int k = 0; k < cut; k++) begin
            send_byte(seq[k], str_done && (k == cut - 1));
        end
        sent = cut;
    endtask

    initial begin
        int         counted;
        int         phase_len;
        int         in_phase;
        int         sent;
        int         pick;
        logic [1:0] fmt;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.in_byte    <= 8'h00;
        in_ch.string_end <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.data      <= FMT_PASS;
        bytes_sent    = 0;
        format_writes = 0;
        burst_left    = 4;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        write_format(FMT_LE);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b1);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h3F, 1'b1);
        send_byte(8'hC3, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);

        write_format(FMT_BE);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE2, 1'b0);
        write_format(FMT_LE);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b1);

        write_format(FMT_RESERVED);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b1);
        write_format(FMT_BE);
        send_byte(8'h41, 1'b1);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            fmt  = (pick < 8) ? FMT_LE : (pick < 16) ? FMT_BE :
                   (pick < 18) ? FMT_PASS : FMT_RESERVED;
            write_format(fmt);
            phase_len = (fmt == FMT_RESERVED) ? $urandom_range(4, 12) : $urandom_range(10, 80);
            in_phase  = 0;
            while (in_phase < phase_len) begin
                send_char(sent);
                in_phase += sent;
                if ($urandom_range(0, 149) == 0) drain();
            end
            if (fmt != FMT_RESERVED) counted += in_phase;
        end

        in_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        $display("summary: %0d input bytes over %0d format writes, %0d output bytes checked",
                 bytes_sent, format_writes, results);
        $display("summary: all formats incl. the unused one, cut-short and invalid sequences");
        if (errors == 0 && outstanding == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

>>> files.f
design/utt_pkg.sv
design/utt_ifs.sv
design/utt_front.sv
design/utt_queue.sv
design/utt_back.sv
design/utf8_to_utf16_transcoder.sv
design/utt_checker.sv
bench/utt_checker.sv
bench/tb.sv
